// ===== src/ttmc_pkg.sv =====
// Shared types and constants for the target track mode controller.
// Used by every module of the block; depends on nothing.
package ttmc_pkg;

  localparam int unsigned COORD_W   = 12;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 12;
  localparam int unsigned SQ_W      = 2 * COORD_W;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W    = $clog2(QUEUE_DEPTH);

  localparam logic [COORD_W-1:0] CENTER_POSITION    = 12'd1500;
  localparam logic [COORD_W-1:0] TILT_PATROL_OFFSET = 12'd100;
  // Patrol tilt, clamped at zero when the offset exceeds center.
  localparam logic [COORD_W-1:0] TILT_PATROL =
    (TILT_PATROL_OFFSET > CENTER_POSITION) ? '0 : (CENTER_POSITION - TILT_PATROL_OFFSET);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_AIM_X         = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AIM_Y         = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_MARGIN   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_HOLD     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_TOL      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PATROL_STEP   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PATROL_MIN    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PATROL_MAX    = 4'd7;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_MANUAL   = 2'd1,
    MODE_TRACKING = 2'd2,
    MODE_LOCKON   = 2'd3
  } ttmc_mode_t;

  typedef struct packed {
    logic [COORD_W-1:0] aim_x;
    logic [COORD_W-1:0] aim_y;
    logic [COORD_W-1:0] lock_margin;
    logic [CNT_W-1:0]   lock_hold_count;
    logic [CNT_W-1:0]   miss_tolerance;
    logic [CNT_W-1:0]   patrol_step;
    logic [COORD_W-1:0] patrol_min;
    logic [COORD_W-1:0] patrol_max;
  } ttmc_cfg_t;

  // Classified tick as it travels from front to back.
  typedef struct packed {
    logic               mode_key;
    logic               frame_valid;
    logic               target_detected;
    logic               in_margin;
    logic [COORD_W-1:0] current_pan;
  } ttmc_item_t;

  typedef struct packed {
    ttmc_mode_t         mode;
    logic               laser_on;
    logic               fire_pulse;
    logic               run_pid;
    logic               clear_integral;
    logic               center_request;
    logic               drive_valid;
    logic [COORD_W-1:0] pan_drive;
    logic [COORD_W-1:0] tilt_drive;
  } ttmc_result_t;

endpackage

// ===== src/ttmc_front.sv =====
// Front end: accepts ticks, squares the aim error and classifies the frame.
// Depends on ttmc_pkg.
module ttmc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ttmc_pkg::ttmc_cfg_t         cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode_key,
  input  logic                        in_frame_valid,
  input  logic                        in_target_detected,
  input  logic [ttmc_pkg::COORD_W-1:0] in_target_x,
  input  logic [ttmc_pkg::COORD_W-1:0] in_target_y,
  input  logic [ttmc_pkg::COORD_W-1:0] in_current_pan,
  output logic                        push_valid,
  input  logic                        push_ready,
  output ttmc_pkg::ttmc_item_t        push_item
);
  import ttmc_pkg::*;

  logic                      stg_valid_r;
  logic                      btn_r, fvalid_r, det_r;
  logic [COORD_W-1:0]        pan_r;
  logic [SQ_W-1:0]           ex_sq_r, ey_sq_r, m_sq_r;
  logic signed [COORD_W:0]   ex, ey;
  logic signed [2*COORD_W+1:0] ex_sq, ey_sq;
  logic [SQ_W-1:0]           m_sq;
  logic [SQ_W:0]             d_sq;
  logic                      take;

  assign in_ready = !stg_valid_r || push_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    ex    = $signed({1'b0, in_target_x}) - $signed({1'b0, cfg.aim_x});
    ey    = $signed({1'b0, in_target_y}) - $signed({1'b0, cfg.aim_y});
    ex_sq = ex * ex;
    ey_sq = ey * ey;
    m_sq  = cfg.lock_margin * cfg.lock_margin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      btn_r    <= in_mode_key;
      fvalid_r <= in_frame_valid;
      det_r    <= in_target_detected;
      pan_r    <= in_current_pan;
      ex_sq_r  <= ex_sq[SQ_W-1:0];
      ey_sq_r  <= ey_sq[SQ_W-1:0];
      m_sq_r   <= m_sq;
    end
  end

  assign d_sq = {1'b0, ex_sq_r} + {1'b0, ey_sq_r};

  always_comb begin
    push_valid                = stg_valid_r;
    push_item.mode_key        = btn_r;
    push_item.frame_valid     = fvalid_r;
    push_item.target_detected = det_r;
    push_item.in_margin       = (d_sq <= {1'b0, m_sq_r});
    push_item.current_pan     = pan_r;
  end

endmodule

// ===== src/ttmc_queue.sv =====
// Short FIFO of classified ticks between front and back.
// Depends on ttmc_pkg.
module ttmc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  ttmc_pkg::ttmc_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output ttmc_pkg::ttmc_item_t pop_item
);
  import ttmc_pkg::*;

  ttmc_item_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     count_r;
  logic                do_push, do_pop;

  assign push_ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/ttmc_back.sv =====
// Back end: mode state machine, lock/miss counters, patrol sweep, result register.
// Depends on ttmc_pkg.
module ttmc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ttmc_pkg::ttmc_cfg_t    cfg,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  ttmc_pkg::ttmc_item_t   pop_item,
  output logic                   res_valid,
  input  logic                   res_ready,
  output ttmc_pkg::ttmc_result_t res
);
  import ttmc_pkg::*;

  ttmc_mode_t          mode_r, mode_nxt, mode_btn;
  logic [CNT_W-1:0]    lock_r, lock_nxt, lock_upd, lock_base;
  logic [CNT_W-1:0]    miss_r, miss_nxt;
  logic [COORD_W-1:0]  sweep_r, sweep_nxt, sweep_base;
  logic                down_r, down_nxt;
  logic                laser_r, laser_nxt;
  logic                res_valid_r;
  ttmc_result_t        res_r, res_nxt;
  logic                step;
  logic                from_manual, frame_act, det_hit, miss_ok, locked;
  logic signed [COORD_W+1:0] p;

  assign pop_ready = !res_valid_r || res_ready;
  assign step      = pop_valid && pop_ready;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  // Decode the tick against the current state.
  always_comb begin
    from_manual = pop_item.mode_key && (mode_r == MODE_MANUAL);
    if (pop_item.mode_key) begin
      mode_btn = (mode_r == MODE_MANUAL) ? MODE_IDLE : MODE_MANUAL;
    end else begin
      mode_btn = mode_r;
    end
    // Leaving manual clears the lock count before the frame is scored.
    lock_base = from_manual ? '0 : lock_r;
    frame_act = (mode_btn != MODE_MANUAL) && pop_item.frame_valid;
    det_hit   = frame_act && pop_item.target_detected;
    miss_ok   = miss_r < cfg.miss_tolerance;
    if (pop_item.in_margin) begin
      lock_upd = (lock_base < cfg.lock_hold_count) ? lock_base + 1'b1 : lock_base;
    end else begin
      lock_upd = '0;
    end
    locked = lock_upd >= cfg.lock_hold_count;
  end

  // Next state.
  always_comb begin
    mode_nxt  = mode_btn;
    lock_nxt  = lock_base;
    miss_nxt  = miss_r;
    laser_nxt = pop_item.mode_key ? 1'b0 : laser_r;
    down_nxt  = down_r;
    if (det_hit) begin
      miss_nxt  = '0;
      lock_nxt  = lock_upd;
      mode_nxt  = locked ? MODE_LOCKON : MODE_TRACKING;
      laser_nxt = locked;
    end else if (frame_act) begin
      lock_nxt  = '0;
      laser_nxt = 1'b0;
      if (miss_ok) begin
        miss_nxt = miss_r + 1'b1;
      end else begin
        mode_nxt = MODE_IDLE;
      end
    end

    sweep_base = (from_manual || det_hit) ? pop_item.current_pan : sweep_r;
    if (down_r) begin
      p = $signed({2'b00, sweep_base}) - $signed({6'b0, cfg.patrol_step});
    end else begin
      p = $signed({2'b00, sweep_base}) + $signed({6'b0, cfg.patrol_step});
    end
    sweep_nxt = sweep_base;
    if (mode_nxt == MODE_IDLE) begin
      if (p >= $signed({2'b00, cfg.patrol_max})) begin
        sweep_nxt = cfg.patrol_max;
        down_nxt  = 1'b1;
      end else if (p <= $signed({2'b00, cfg.patrol_min})) begin
        sweep_nxt = cfg.patrol_min;
        down_nxt  = 1'b0;
      end else begin
        sweep_nxt = p[COORD_W-1:0];
      end
    end
  end

  // Result word.
  always_comb begin
    res_nxt.mode           = mode_nxt;
    res_nxt.laser_on       = laser_nxt;
    res_nxt.fire_pulse     = det_hit && locked && (mode_btn != MODE_LOCKON);
    res_nxt.run_pid        = det_hit;
    res_nxt.clear_integral = from_manual || (frame_act && !pop_item.target_detected && !miss_ok);
    res_nxt.center_request = pop_item.mode_key && (mode_r != MODE_MANUAL);
    res_nxt.drive_valid    = (mode_nxt == MODE_IDLE);
    res_nxt.pan_drive      = (mode_nxt == MODE_IDLE) ? sweep_nxt : '0;
    res_nxt.tilt_drive     = (mode_nxt == MODE_IDLE) ? TILT_PATROL : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      lock_r      <= '0;
      miss_r      <= '0;
      sweep_r     <= CENTER_POSITION;
      down_r      <= 1'b0;
      laser_r     <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (step) begin
        mode_r  <= mode_nxt;
        lock_r  <= lock_nxt;
        miss_r  <= miss_nxt;
        sweep_r <= sweep_nxt;
        down_r  <= down_nxt;
        laser_r <= laser_nxt;
      end
      if (pop_ready) begin
        res_valid_r <= pop_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== src/target_track_mode_controller_unit.sv =====
// Top level of the target track mode controller: configuration registers,
// front end, tick queue and back end. Depends on ttmc_pkg, ttmc_front,
// ttmc_queue and ttmc_back.
//
//   channel  | handshake            | word
//   ---------+----------------------+---------------------------------------------
//   in_      | in_valid / in_ready  | button, frame flags, target x/y, current pan
//   out_     | out_valid / out_ready| mode, laser, pulses, patrol drive values
//   cfg_     | cfg_valid / cfg_ready| register index (4 bits), data (12 bits)
//
// One tick per cycle sustained while out_ready holds high; the accepting edge
// loads the front register holding the squared error, the tick then moves into
// the queue and from there into the result register, which raises out_valid.
// The lock/miss/sweep update in the back end is combinational and registered
// with each step, so the back end can take a new tick while out_ready is high.
// Reset is synchronous, active low; it clears mode, counters and queue, sets the
// sweep to center and loads the register reset values. cfg_ready is always high.
// A stalled output holds the back end; the four-entry queue lets the front keep
// accepting until it fills, then in_ready drops.
module target_track_mode_controller_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ttmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttmc_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode_key,
  input  logic                            in_frame_valid,
  input  logic                            in_target_detected,
  input  logic [ttmc_pkg::COORD_W-1:0]    in_target_x,
  input  logic [ttmc_pkg::COORD_W-1:0]    in_target_y,
  input  logic [ttmc_pkg::COORD_W-1:0]    in_current_pan,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_mode,
  output logic                            out_laser_on,
  output logic                            out_fire_pulse,
  output logic                            out_run_pid,
  output logic                            out_clear_integral,
  output logic                            out_center_request,
  output logic                            out_drive_valid,
  output logic [ttmc_pkg::COORD_W-1:0]    out_pan_drive,
  output logic [ttmc_pkg::COORD_W-1:0]    out_tilt_drive
);
  import ttmc_pkg::*;

  ttmc_cfg_t    cfg_r;
  ttmc_item_t   push_item, pop_item;
  ttmc_result_t res;
  logic         push_valid, push_ready, pop_valid, pop_ready;

  assign cfg_ready = 1'b1;

  // Register file; writes to unknown indexes drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.aim_x           <= 12'd160;
      cfg_r.aim_y           <= 12'd120;
      cfg_r.lock_margin     <= 12'd10;
      cfg_r.lock_hold_count <= 8'd5;
      cfg_r.miss_tolerance  <= 8'd10;
      cfg_r.patrol_step     <= 8'd5;
      cfg_r.patrol_min      <= 12'd1000;
      cfg_r.patrol_max      <= 12'd2000;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_AIM_X:       cfg_r.aim_x           <= cfg_data;
        CFG_AIM_Y:       cfg_r.aim_y           <= cfg_data;
        CFG_LOCK_MARGIN: cfg_r.lock_margin     <= cfg_data;
        CFG_LOCK_HOLD:   cfg_r.lock_hold_count <= cfg_data[CNT_W-1:0];
        CFG_MISS_TOL:    cfg_r.miss_tolerance  <= cfg_data[CNT_W-1:0];
        CFG_PATROL_STEP: cfg_r.patrol_step     <= cfg_data[CNT_W-1:0];
        CFG_PATROL_MIN:  cfg_r.patrol_min      <= cfg_data;
        CFG_PATROL_MAX:  cfg_r.patrol_max      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify each tick: square the aim error, compare against the margin.
  ttmc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode_key        (in_mode_key),
    .in_frame_valid     (in_frame_valid),
    .in_target_detected (in_target_detected),
    .in_target_x        (in_target_x),
    .in_target_y        (in_target_y),
    .in_current_pan     (in_current_pan),
    .push_valid         (push_valid),
    .push_ready         (push_ready),
    .push_item          (push_item)
  );

  // Decouple front from back so each can stall on its own.
  ttmc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Advance mode, counters and sweep; hold the result until taken.
  ttmc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_mode           = res.mode;
  assign out_laser_on       = res.laser_on;
  assign out_fire_pulse     = res.fire_pulse;
  assign out_run_pid        = res.run_pid;
  assign out_clear_integral = res.clear_integral;
  assign out_center_request = res.center_request;
  assign out_drive_valid    = res.drive_valid;
  assign out_pan_drive      = res.pan_drive;
  assign out_tilt_drive     = res.tilt_drive;

endmodule

// ===== src/ttmc_checker.sv =====
// Port-level checks for the target track mode controller, bound to the top level.
// Depends on ttmc_pkg and target_track_mode_controller_unit.
module ttmc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   out_mode,
  input logic                         out_laser_on,
  input logic                         out_fire_pulse,
  input logic                         out_center_request,
  input logic                         out_drive_valid,
  input logic [ttmc_pkg::COORD_W-1:0] out_pan_drive,
  input logic [ttmc_pkg::COORD_W-1:0] out_tilt_drive
);
  import ttmc_pkg::*;

  // A fire pulse only comes with lock-on and the laser lit.
  a_fire_lock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fire_pulse |-> out_mode == MODE_LOCKON && out_laser_on)
    else $error("fire pulse outside lock-on");

  // Patrol drive only in idle, and drive values zero otherwise.
  a_drive_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive_valid == (out_mode == MODE_IDLE)) &&
                  (out_drive_valid || (out_pan_drive == '0 && out_tilt_drive == '0)))
    else $error("patrol drive inconsistent with mode");

  // Center request only on entry into manual, with the laser off.
  a_center_manual: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_center_request |-> out_mode == MODE_MANUAL && !out_laser_on)
    else $error("center request outside manual entry");

  // Laser is only lit in lock-on.
  a_laser_lock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_laser_on |-> out_mode == MODE_LOCKON)
    else $error("laser on outside lock-on");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mode) && $stable(out_pan_drive))
    else $error("result changed while stalled");

endmodule

bind target_track_mode_controller_unit ttmc_checker u_ttmc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_mode           (out_mode),
  .out_laser_on       (out_laser_on),
  .out_fire_pulse     (out_fire_pulse),
  .out_center_request (out_center_request),
  .out_drive_valid    (out_drive_valid),
  .out_pan_drive      (out_pan_drive),
  .out_tilt_drive     (out_tilt_drive)
);

// ===== tb/sv/target_track_mode_controller_unit_test.sv =====
// Self-checking testbench for target_track_mode_controller_unit: a small checker
// class that predicts each result word, and the top module that drives the block.
// Depends on ttmc_pkg and the RTL of the unit.
package ttmc_test_pkg;
  import ttmc_pkg::*;

  typedef struct packed {
    logic               button;
    logic               frame;
    logic               detected;
    logic [COORD_W-1:0] tx;
    logic [COORD_W-1:0] ty;
    logic [COORD_W-1:0] pan;
  } tick_t;

  class track_mode_checker;
    ttmc_cfg_t          regs;
    ttmc_mode_t         mode;
    logic [CNT_W-1:0]   lock_run;
    logic [CNT_W-1:0]   miss_run;
    logic [COORD_W-1:0] sweep_pos;
    logic               sweep_down;
    logic               laser;
    ttmc_result_t       due_results[$];
    int unsigned        mismatch_count;

    function new();
      regs.aim_x           = 12'd160;
      regs.aim_y           = 12'd120;
      regs.lock_margin     = 12'd10;
      regs.lock_hold_count = 8'd5;
      regs.miss_tolerance  = 8'd10;
      regs.patrol_step     = 8'd5;
      regs.patrol_min      = 12'd1000;
      regs.patrol_max      = 12'd2000;
      mode       = MODE_IDLE;
      lock_run   = '0;
      miss_run   = '0;
      sweep_pos  = CENTER_POSITION;
      sweep_down = 1'b0;
      laser      = 1'b0;
      mismatch_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        CFG_AIM_X:       regs.aim_x           = val;
        CFG_AIM_Y:       regs.aim_y           = val;
        CFG_LOCK_MARGIN: regs.lock_margin     = val;
        CFG_LOCK_HOLD:   regs.lock_hold_count = val[CNT_W-1:0];
        CFG_MISS_TOL:    regs.miss_tolerance  = val[CNT_W-1:0];
        CFG_PATROL_STEP: regs.patrol_step     = val[CNT_W-1:0];
        CFG_PATROL_MIN:  regs.patrol_min      = val;
        CFG_PATROL_MAX:  regs.patrol_max      = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    // Advance the mode state by one accepted tick and queue the result it implies.
    function void note_tick(tick_t t);
      ttmc_result_t r;
      longint       ex, ey, dist_sq, lim_sq;
      int           p, tilt;
      r = '0;
      if (t.button) begin
        if (mode == MODE_MANUAL) begin
          sweep_pos = t.pan;
          r.clear_integral = 1'b1;
          lock_run = '0;
          laser = 1'b0;
          mode = MODE_IDLE;
        end else begin
          laser = 1'b0;
          r.center_request = 1'b1;
          mode = MODE_MANUAL;
        end
      end
      if (mode != MODE_MANUAL) begin
        if (t.frame) begin
          if (t.detected) begin
            ex = longint'(t.tx) - longint'(regs.aim_x);
            ey = longint'(t.ty) - longint'(regs.aim_y);
            dist_sq = ex * ex + ey * ey;
            lim_sq = longint'(regs.lock_margin) * longint'(regs.lock_margin);
            miss_run = '0;
            if (dist_sq <= lim_sq) begin
              if (lock_run < regs.lock_hold_count) lock_run = lock_run + 1'b1;
            end else begin
              lock_run = '0;
            end
            if (lock_run >= regs.lock_hold_count) begin
              if (mode != MODE_LOCKON) r.fire_pulse = 1'b1;
              mode = MODE_LOCKON;
              laser = 1'b1;
            end else begin
              mode = MODE_TRACKING;
              laser = 1'b0;
            end
            r.run_pid = 1'b1;
            sweep_pos = t.pan;
          end else if (miss_run < regs.miss_tolerance) begin
            miss_run = miss_run + 1'b1;
            lock_run = '0;
            laser = 1'b0;
          end else begin
            mode = MODE_IDLE;
            lock_run = '0;
            laser = 1'b0;
            r.clear_integral = 1'b1;
          end
        end
        if (mode == MODE_IDLE) begin
          p = sweep_down ? int'(sweep_pos) - int'(regs.patrol_step)
                         : int'(sweep_pos) + int'(regs.patrol_step);
          if (p >= int'(regs.patrol_max)) begin
            p = int'(regs.patrol_max);
            sweep_down = 1'b1;
          end else if (p <= int'(regs.patrol_min)) begin
            p = int'(regs.patrol_min);
            sweep_down = 1'b0;
          end
          sweep_pos = p[COORD_W-1:0];
          tilt = int'(CENTER_POSITION) - int'(TILT_PATROL_OFFSET);
          if (tilt < 0) tilt = 0;
          r.drive_valid = 1'b1;
          r.pan_drive = sweep_pos;
          r.tilt_drive = tilt[COORD_W-1:0];
        end
      end
      r.mode = mode;
      r.laser_on = laser;
      due_results.push_back(r);
    endfunction

    function void check_result(ttmc_result_t got);
      ttmc_result_t want;
      logic         bad;
      if (due_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result word with nothing expected (mode=%0d)", $realtime, got.mode);
        return;
      end
      want = due_results.pop_front();
      bad = (got.mode !== want.mode) || (got.laser_on !== want.laser_on) ||
            (got.fire_pulse !== want.fire_pulse) || (got.run_pid !== want.run_pid) ||
            (got.clear_integral !== want.clear_integral) ||
            (got.center_request !== want.center_request) ||
            (got.drive_valid !== want.drive_valid) ||
            (got.pan_drive !== want.pan_drive) || (got.tilt_drive !== want.tilt_drive);
      if (bad) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: result word differs", $realtime);
          $display("  expected mode=%0d laser=%b fire=%b pid=%b clr=%b ctr=%b drv=%b pan=%0d tilt=%0d",
                   want.mode, want.laser_on, want.fire_pulse, want.run_pid, want.clear_integral,
                   want.center_request, want.drive_valid, want.pan_drive, want.tilt_drive);
          $display("  actual   mode=%0d laser=%b fire=%b pid=%b clr=%b ctr=%b drv=%b pan=%0d tilt=%0d",
                   got.mode, got.laser_on, got.fire_pulse, got.run_pid, got.clear_integral,
                   got.center_request, got.drive_valid, got.pan_drive, got.tilt_drive);
        end
      end
    endfunction
  endclass

endpackage

module target_track_mode_controller_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ttmc_pkg::*;
  import ttmc_test_pkg::*;

  localparam int unsigned REG_COUNT       = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 64;
  localparam int unsigned HOLD_OFF_AFTER  = 400;
  localparam int unsigned PHASE_COUNT     = 8;
  localparam int unsigned PHASE_TICKS     = 170;

  typedef enum {BURST_AIM, BURST_MISS, BURST_PATROL, BURST_BUTTON, BURST_NOISE} burst_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_mode_key = 1'b0;
  logic                 in_frame_valid = 1'b0;
  logic                 in_target_detected = 1'b0;
  logic [COORD_W-1:0]   in_target_x = '0;
  logic [COORD_W-1:0]   in_target_y = '0;
  logic [COORD_W-1:0]   in_current_pan = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_mode;
  logic                 out_laser_on;
  logic                 out_fire_pulse;
  logic                 out_run_pid;
  logic                 out_clear_integral;
  logic                 out_center_request;
  logic                 out_drive_valid;
  logic [COORD_W-1:0]   out_pan_drive;
  logic [COORD_W-1:0]   out_tilt_drive;

  track_mode_checker sb = new();
  ttmc_cfg_t         cur_cfg;
  int unsigned       quiet_left = 0;
  int unsigned       results_seen = 0;

  target_track_mode_controller_unit dut (.*);

  always #6 clk = ~clk;

  // Global watchdog: far beyond the slowest legal run (about 1400 ticks, each
  // with the longest sender gap and receiver stall, plus the one hold-off).
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // Sender gap: mostly back-to-back or short, now and then long, with
  // stretches of no gaps at all.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_left != 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) quiet_left = $urandom_range(20, 60);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic tick_t mk_tick(int b, int f, int d, int x, int y, int pan);
    tick_t t;
    t.button = b[0];
    t.frame = f[0];
    t.detected = d[0];
    t.tx = x[COORD_W-1:0];
    t.ty = y[COORD_W-1:0];
    t.pan = pan[COORD_W-1:0];
    return t;
  endfunction

  // Coordinate around an aim value, spread a little past the margin.
  function automatic logic [COORD_W-1:0] near_aim(logic [COORD_W-1:0] c);
    int span, v;
    span = (cur_cfg.lock_margin > 300) ? 300 : int'(cur_cfg.lock_margin) + 1;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[COORD_W-1:0];
  endfunction

  // Offer one input word, hold it until accepted, then let the checker see it.
  task automatic drive_tick(input tick_t t);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_mode_key        <= t.button;
    in_frame_valid     <= t.frame;
    in_target_detected <= t.detected;
    in_target_x        <= t.tx;
    in_target_y        <= t.ty;
    in_current_pan     <= t.pan;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_tick(t);
  endtask

  // Drop the input and wait until every expected result word has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Load a full register set; an unused index goes first and must change nothing.
  task automatic load_setting(input ttmc_cfg_t c);
    logic [CFG_IDX_W-1:0] junk_idx;
    settle();
    junk_idx = CFG_IDX_W'($urandom_range(REG_COUNT, (1 << CFG_IDX_W) - 1));
    write_cfg(junk_idx, CFG_DAT_W'($urandom_range(0, 4095)));
    write_cfg(CFG_AIM_X, c.aim_x);
    write_cfg(CFG_AIM_Y, c.aim_y);
    write_cfg(CFG_LOCK_MARGIN, c.lock_margin);
    write_cfg(CFG_LOCK_HOLD, 12'(c.lock_hold_count));
    write_cfg(CFG_MISS_TOL, 12'(c.miss_tolerance));
    write_cfg(CFG_PATROL_STEP, 12'(c.patrol_step));
    write_cfg(CFG_PATROL_MIN, c.patrol_min);
    write_cfg(CFG_PATROL_MAX, c.patrol_max);
    cfg_valid <= 1'b0;
    cur_cfg = c;
  endtask

  // Settings per phase: both extremes first, then tight counts, then random ones.
  function automatic ttmc_cfg_t pick_setting(int unsigned k);
    ttmc_cfg_t c;
    logic [COORD_W-1:0] a, b;
    case (k)
      0: c = '{aim_x: 12'd0, aim_y: 12'd0, lock_margin: 12'd0, lock_hold_count: 8'd0,
               miss_tolerance: 8'd0, patrol_step: 8'd0, patrol_min: 12'd0,
               patrol_max: 12'd4095};
      1: c = '{aim_x: 12'd4095, aim_y: 12'd4095, lock_margin: 12'd4095,
               lock_hold_count: 8'd255, miss_tolerance: 8'd255, patrol_step: 8'd255,
               patrol_min: 12'd4095, patrol_max: 12'd0};
      2: c = '{aim_x: 12'd2048, aim_y: 12'd1024, lock_margin: 12'd3, lock_hold_count: 8'd1,
               miss_tolerance: 8'd1, patrol_step: 8'd255, patrol_min: 12'd0,
               patrol_max: 12'd4095};
      default: begin
        a = COORD_W'($urandom_range(0, 4095));
        b = COORD_W'($urandom_range(0, 4095));
        c.aim_x           = COORD_W'($urandom_range(0, 4095));
        c.aim_y           = COORD_W'($urandom_range(0, 4095));
        c.lock_margin     = COORD_W'($urandom_range(0, 60));
        c.lock_hold_count = CNT_W'($urandom_range(0, 8));
        c.miss_tolerance  = CNT_W'($urandom_range(0, 12));
        c.patrol_step     = CNT_W'($urandom_range(0, 255));
        // Mostly an ordered sweep window, sometimes an inverted one.
        if (($urandom_range(0, 4) == 0) == (a < b)) begin
          c.patrol_min = b;
          c.patrol_max = a;
        end else begin
          c.patrol_min = a;
          c.patrol_max = b;
        end
      end
    endcase
    return c;
  endfunction

  // Random traffic built from bursts: runs of aimed frames that build up a lock,
  // runs of misses that burn through the grace period, plain patrol ticks,
  // button presses and pure noise.
  task automatic run_traffic(input int unsigned n_ticks);
    int unsigned sent, len, r, cap;
    burst_t      kind;
    tick_t       t;
    sent = 0;
    while (sent < n_ticks) begin
      r = $urandom_range(0, 99);
      kind = (r < 45) ? BURST_AIM : (r < 65) ? BURST_MISS : (r < 80) ? BURST_PATROL :
             (r < 88) ? BURST_BUTTON : BURST_NOISE;
      case (kind)
        BURST_AIM: begin
          cap = (cur_cfg.lock_hold_count > 20) ? 24 : int'(cur_cfg.lock_hold_count) + 4;
          len = $urandom_range(1, cap);
        end
        BURST_MISS: begin
          cap = (cur_cfg.miss_tolerance > 26) ? 30 : int'(cur_cfg.miss_tolerance) + 4;
          len = $urandom_range(1, cap);
        end
        BURST_PATROL: len = $urandom_range(1, 30);
        BURST_BUTTON: len = 1;
        default:      len = $urandom_range(1, 5);
      endcase
      for (int unsigned i = 0; i < len; i++) begin
        t.button   = 1'($urandom_range(0, 1));
        t.frame    = 1'($urandom_range(0, 1));
        t.detected = 1'($urandom_range(0, 1));
        t.tx       = COORD_W'($urandom_range(0, 4095));
        t.ty       = COORD_W'($urandom_range(0, 4095));
        t.pan      = COORD_W'($urandom_range(0, 4095));
        if (kind != BURST_NOISE && kind != BURST_BUTTON) begin
          t.button = ($urandom_range(0, 49) == 0);
          // Leave manual mode at the head of most bursts so frames get handled.
          if (i == 0 && sb.mode == MODE_MANUAL && $urandom_range(0, 4) != 0) t.button = 1'b1;
        end
        case (kind)
          BURST_AIM: begin
            t.frame = ($urandom_range(0, 4) != 0);
            t.detected = 1'b1;
            if ($urandom_range(0, 6) != 0) begin
              t.tx = near_aim(cur_cfg.aim_x);
              t.ty = near_aim(cur_cfg.aim_y);
            end
          end
          BURST_MISS: begin
            t.frame = ($urandom_range(0, 5) != 0);
            t.detected = ($urandom_range(0, 15) == 0);
          end
          BURST_PATROL: t.frame = 1'b0;
          BURST_BUTTON: t.button = 1'b1;
          default: ;
        endcase
        drive_tick(t);
        sent++;
      end
    end
  endtask

  // Stimulus: reset, a directed pass under the reset values, then phases of
  // random traffic, each under its own register setting.
  initial begin
    cur_cfg = sb.regs;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    drive_tick(mk_tick(0, 0, 0, 0, 0, 0));           // patrol step from center
    drive_tick(mk_tick(1, 1, 1, 160, 120, 0));       // enter manual, frame ignored
    drive_tick(mk_tick(0, 1, 1, 4095, 4095, 4095));  // frame in manual is ignored
    drive_tick(mk_tick(1, 0, 0, 0, 0, 4095));        // leave manual, sweep hits max
    drive_tick(mk_tick(0, 0, 0, 4095, 0, 0));        // sweep turns down
    drive_tick(mk_tick(0, 1, 1, 160, 120, 1234));    // build the lock count
    drive_tick(mk_tick(0, 1, 1, 170, 120, 1234));
    drive_tick(mk_tick(0, 1, 1, 160, 110, 1234));
    drive_tick(mk_tick(0, 1, 1, 166, 128, 1234));    // exactly on the margin
    drive_tick(mk_tick(0, 1, 1, 150, 120, 1234));    // lock-on with fire pulse
    drive_tick(mk_tick(0, 1, 1, 160, 120, 1234));    // stay locked, no second pulse
    drive_tick(mk_tick(0, 1, 0, 0, 0, 0));           // miss in grace keeps lock-on mode
    drive_tick(mk_tick(0, 1, 1, 171, 120, 2222));    // just outside: tracking
    drive_tick(mk_tick(0, 1, 1, 0, 4095, 4095));     // far corner
    for (int i = 0; i < 11; i++)                     // burn grace, then back to patrol
      drive_tick(mk_tick(0, 1, 0, 4095, 0, 0));

    for (int unsigned k = 0; k < PHASE_COUNT; k++) begin
      load_setting(pick_setting(k));
      run_traffic(PHASE_TICKS);
    end

    settle();
    repeat (8) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Receiver: segments of always-ready, light stalls and heavy stalls, plus one
  // long hold-off so the queue fills up and in_ready drops.
  initial begin
    int unsigned seg_len, style, n;
    bit          held_off;
    held_off = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      seg_len = $urandom_range(10, 80);
      style = $urandom_range(0, 2);
      n = 0;
      while (n < seg_len) begin
        if (style == 2 && $urandom_range(0, 7) == 0) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(5, 25)) @(posedge clk);
          n += 5;
        end else begin
          out_ready <= (style == 0) ? 1'b1 :
                       (style == 1) ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1));
          @(posedge clk);
          n++;
        end
      end
    end
  end

  // Check every result word at the edge where it is taken.
  always @(posedge clk) begin : take_result
    ttmc_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.mode           = ttmc_mode_t'(out_mode);
      got.laser_on       = out_laser_on;
      got.fire_pulse     = out_fire_pulse;
      got.run_pid        = out_run_pid;
      got.clear_integral = out_clear_integral;
      got.center_request = out_center_request;
      got.drive_valid    = out_drive_valid;
      got.pan_drive      = out_pan_drive;
      got.tilt_drive     = out_tilt_drive;
      sb.check_result(got);
      results_seen++;
    end
  end

endmodule
